@@ sv/bstk_pkg.sv @@
// ============================================================================
// Bounded stack package
// Payload types, operation codes and arithmetic constants shared by the
// bounded stack, its channel interface and its testbench.
// ============================================================================
package bstk_pkg;

    // Fixed field widths of the channel payloads
    localparam int DATA_BITS  = 32;
    localparam int DEPTH_BITS = 6;

    // Operation codes carried in the mode field
    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_DIGITS = 2'd2;
    localparam logic [1:0] MODE_PAL    = 2'd3;

    // Value returned by a pop that finds the stack empty
    localparam logic signed [DATA_BITS-1:0] POP_EMPTY_VALUE = -32'sd1;

    // Division by ten: floor(n * DIGIT_RECIP / 2**DIGIT_SHIFT) is exact for
    // every 32-bit unsigned n.
    localparam logic [31:0] DIGIT_RECIP = 32'hCCCC_CCCD;
    localparam int          DIGIT_SHIFT = 35;
    localparam logic [3:0]  RADIX       = 4'd10;

    // One input item
    typedef struct packed {
        logic [1:0]                  mode;
        logic signed [DATA_BITS-1:0] push_value;
    } item_t;

    // One result item
    typedef struct packed {
        logic signed [DATA_BITS-1:0] pop_value;
        logic                        was_empty;
        logic                        is_palindrome;
        logic [DEPTH_BITS-1:0]       depth_now;
        logic                        now_full;
    } result_t;

endpackage

@@ sv/bstk_if.sv @@
// ============================================================================
// Bounded stack channel
// Valid/ready channel carrying one payload per transfer. A transfer takes
// place at a rising clock edge where valid and ready are both high.
// ============================================================================
interface bstk_if
    import bstk_pkg::*;
#(
    parameter type payload_t = item_t
);

    logic     valid;
    logic     ready;
    payload_t data;

    // The producing side drives valid and data, the consuming side ready.
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ sv/bounded_stack_with_palindrome_check.sv @@
// ============================================================================
// Bounded stack with palindrome check
// LIFO stack of signed words with push, pop, decimal digit push and a
// palindrome test over the stored entries.
// ============================================================================
// Each item accepted on the item channel gives exactly one transfer on the
// result channel. A push, a pop of an empty stack and a palindrome check of
// an empty stack complete in the cycle of acceptance. A pop forms its result
// in the pop read state, from the registered read data of the entry RAM. A
// digit push works through the digits in turn: a reciprocal multiply state,
// then a state that forms the remainder and writes the RAM. A palindrome check
// reads a pair from the two RAM copies per cycle, walking in from both ends,
// then makes the last compare in a final state. The result side holds up to
// two finished results, so the next item is taken while one result waits;
// item ready falls while a multi-cycle operation runs or both result slots
// are full. The entries are not cleared by reset; only the fill count is.
module bounded_stack_with_palindrome_check
    import bstk_pkg::*;
#(
    parameter int CAPACITY  = 32,
    parameter int WORD_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    bstk_if.sink          item,
    bstk_if.source        result
);

    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int EXT_BITS = (WORD_BITS > DATA_BITS) ? WORD_BITS : DATA_BITS;

    // Sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_POP_RD   = 3'd1;
    localparam logic [2:0] ST_DIG_MUL  = 3'd2;
    localparam logic [2:0] ST_DIG_PUSH = 3'd3;
    localparam logic [2:0] ST_PAL_RD   = 3'd4;
    localparam logic [2:0] ST_PAL_END  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [AW-1:0]        lo_reg, lo_next;
    logic [AW-1:0]        hi_reg, hi_next;
    logic                 pal_reg, pal_next;
    logic                 cmp_pend_reg, cmp_pend_next;
    logic [31:0]          mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [63:0]          prod_reg, prod_next;

    logic                 acc;
    logic                 full;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic [AW-1:0]        rd_addr_a;
    logic [WORD_BITS-1:0] rd_data_a;
    logic [WORD_BITS-1:0] rd_data_b;
    logic                 pair_equal;
    logic [EXT_BITS-1:0]  pop_ext;

    logic [31:0]          quot;
    logic [31:0]          quot_x10;
    logic [3:0]           rem;
    logic signed [4:0]    digit;

    logic                 res_valid;
    result_t              res;

    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    result_t              out_data_reg, out_data_next;
    result_t              skid_data_reg, skid_data_next;
    logic                 out_taken;

    // Handshake on the item channel
    assign item.ready = (state_reg == ST_IDLE) && !skid_valid_reg;
    assign acc        = item.valid && item.ready;
    assign full       = (cnt_reg == CW'(CAPACITY));

    // Two copies of the entries, written together, so that the palindrome
    // walk reads both ends in the same cycle.
    bstk_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ram_lo (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    bstk_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ram_hi (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (hi_reg),
        .rd_data (rd_data_b)
    );

    // Port A reads the top entry for a pop, else the low end of the walk.
    assign rd_addr_a  = (state_reg == ST_PAL_RD) ? lo_reg : AW'(cnt_reg - CW'(1));
    assign pair_equal = (rd_data_a == rd_data_b);
    assign pop_ext    = EXT_BITS'(signed'(rd_data_a));

    // Digit extraction from the registered reciprocal product
    assign quot     = 32'(prod_reg >> DIGIT_SHIFT);
    assign quot_x10 = 32'(quot * 32'(RADIX));
    assign rem      = 4'(mag_reg - quot_x10);
    assign digit    = neg_reg ? -signed'({1'b0, rem}) : signed'({1'b0, rem});

    // Sequencer: operation decode, RAM access and result formation
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        pal_next      = pal_reg;
        cmp_pend_next = 1'b0;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        prod_next     = prod_reg;
        wr_en         = 1'b0;
        wr_data       = WORD_BITS'(item.data.push_value);
        res_valid     = 1'b0;
        res           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (item.data.mode)
                        MODE_PUSH:
                        begin
                            if (!full)
                            begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                            res_valid = 1'b1;
                        end
                        MODE_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_valid     = 1'b1;
                                res.pop_value = POP_EMPTY_VALUE;
                                res.was_empty = 1'b1;
                            end
                            else
                            begin
                                cnt_next   = cnt_reg - CW'(1);
                                state_next = ST_POP_RD;
                            end
                        end
                        MODE_DIGITS:
                        begin
                            neg_next   = item.data.push_value[DATA_BITS-1];
                            mag_next   = item.data.push_value[DATA_BITS-1]
                                         ? 32'(-item.data.push_value)
                                         : 32'(item.data.push_value);
                            state_next = ST_DIG_MUL;
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_valid         = 1'b1;
                                res.is_palindrome = 1'b1;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = AW'(cnt_reg - CW'(1));
                                pal_next   = 1'b1;
                                state_next = ST_PAL_RD;
                            end
                        end
                    endcase
                end
            end

            ST_POP_RD:
            begin
                res_valid     = 1'b1;
                res.pop_value = pop_ext[DATA_BITS-1:0];
                state_next    = ST_IDLE;
            end

            ST_DIG_MUL:
            begin
                prod_next  = 64'(mag_reg) * 64'(DIGIT_RECIP);
                state_next = ST_DIG_PUSH;
            end

            ST_DIG_PUSH:
            begin
                // A digit that meets a full stack is dropped.
                wr_data = WORD_BITS'(digit);
                if (!full)
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
                // A negative number gives only its truncated remainder.
                if (neg_reg || (quot == '0))
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mag_next   = quot;
                    state_next = ST_DIG_MUL;
                end
            end

            ST_PAL_RD:
            begin
                // Compare the pair read in the previous cycle, issue the next.
                if (cmp_pend_reg && !pair_equal)
                begin
                    pal_next = 1'b0;
                end
                cmp_pend_next = 1'b1;
                lo_next       = lo_reg + AW'(1);
                hi_next       = hi_reg - AW'(1);
                if ((AW + 1)'(lo_reg) + (AW + 1)'(1) >= (AW + 1)'(hi_reg))
                begin
                    state_next = ST_PAL_END;
                end
            end

            ST_PAL_END:
            begin
                res_valid         = 1'b1;
                res.is_palindrome = pal_reg && pair_equal;
                state_next        = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res.depth_now = DEPTH_BITS'(cnt_next);
        res.now_full  = (cnt_next == CW'(CAPACITY));
    end

    // Result side: an output register backed by one skid slot
    assign out_taken = out_valid_reg && result.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (out_taken)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = res_valid;
                skid_data_next  = res;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = res_valid;
            out_data_next  = res;
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            cmp_pend_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            cmp_pend_reg   <= cmp_pend_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        pal_reg       <= pal_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        prod_reg      <= prod_next;
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef NO_ASSERTIONS
    // The skid slot only fills behind a waiting output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds a result while the output register is empty");

    // The fill count never passes the capacity.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("fill count exceeds capacity");

    // The palindrome walk never crosses its two ends.
    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAL_RD) |-> (lo_reg <= hi_reg))
        else $error("palindrome walk pointers crossed");

    // A pop of a non-empty stack removes exactly one entry.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (item.data.mode == MODE_POP) && (cnt_reg != '0))
        |=> (cnt_reg == $past(cnt_reg) - CW'(1)))
        else $error("pop did not decrement the fill count");

    // An empty pop reports an empty stack.
    a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.was_empty) |-> (result.data.depth_now == '0))
        else $error("empty pop reported a non-zero depth");
`endif

endmodule

@@ sv/bstk_ram.sv @@
// ============================================================================
// Bounded stack RAM
// Simple dual-port synchronous RAM: one write port and one read port, with
// the read data registered. Contents are undefined until written.
// ============================================================================
module bstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ tb/testbench.sv @@
// ============================================================================
// Bounded stack with palindrome check: testbench
// Drives push, pop, digit push and palindrome check items through the item
// channel with random gaps, stalls the result channel at random, and checks
// every result transfer against a cycle-free model of the stack.
// ============================================================================
module testbench
    import bstk_pkg::*;
();

    localparam int CAP         = 32;
    localparam int PLAN_ITEMS  = 1025;
    localparam int TAIL_CYCLES = 50;
    localparam int CYCLE_LIMIT = 400000;

    // One planned item, with a flag that holds it back until the block is idle
    typedef struct {
        item_t op;
        bit    wait_idle;
    } planned_op_t;

    logic clk = 1'b0;
    logic rst_n;

    bstk_if #(.payload_t(item_t))   item_ch ();
    bstk_if #(.payload_t(result_t)) result_ch ();

    bounded_stack_with_palindrome_check #(
        .CAPACITY  (CAP),
        .WORD_BITS (DATA_BITS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // Stimulus queue and store of predicted results
    planned_op_t pending_ops[$];
    result_t     awaited_results[$];

    // Model state of the stack
    logic signed [DATA_BITS-1:0] held_words [CAP];
    int                          held_count;

    // Depth as seen by the stimulus planner, used to shape sequences
    int plan_depth;
    bit hold_next;

    int fail_count;
    int cycle_count;
    bit item_fired;
    bit result_fired;
    int send_gap;
    int take_gap;
    bit send_steady;
    bit take_steady;

    // Clock generation
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Model: store one word unless the stack is full.
    function automatic void store_word(logic signed [DATA_BITS-1:0] w);
        if (held_count < CAP)
        begin
            held_words[held_count] = w;
            held_count++;
        end
    endfunction

    // Model: apply one item to the stack and return the result it gives.
    function automatic result_t stack_apply(item_t op);
        result_t r;
        longint  n;
        int      i;
        int      j;
        r = '0;
        case (op.mode)
            MODE_PUSH:
                store_word(op.push_value);
            MODE_POP:
                if (held_count == 0)
                begin
                    r.pop_value = POP_EMPTY_VALUE;
                    r.was_empty = 1'b1;
                end
                else
                begin
                    held_count--;
                    r.pop_value = held_words[held_count];
                end
            MODE_DIGITS:
            begin
                // Truncating division: a negative value yields one digit only.
                n = longint'(op.push_value);
                do
                begin
                    store_word(DATA_BITS'(n % 10));
                    n = n / 10;
                end
                while (n > 0);
            end
            default:
            begin
                r.is_palindrome = 1'b1;
                i = 0;
                j = held_count;
                while (i < j)
                begin
                    if (held_words[i] !== held_words[j - 1])
                        r.is_palindrome = 1'b0;
                    i++;
                    j--;
                end
            end
        endcase
        r.depth_now = DEPTH_BITS'(held_count);
        r.now_full  = (held_count == CAP);
        return r;
    endfunction

    // Draw the idle cycles before the next transfer, with calm stretches.
    function automatic int draw_wait(inout bit steady);
        if ($urandom_range(0, 49) == 0)
            steady = !steady;
        return steady ? 0 : $urandom_range(0, 13);
    endfunction

    // Planner: append one item and track the depth it leaves behind.
    task automatic queue_op(input logic [1:0] mode, input logic signed [DATA_BITS-1:0] value);
        planned_op_t p;
        longint      n;
        int          digits;
        p.op.mode       = mode;
        p.op.push_value = value;
        p.wait_idle     = hold_next;
        hold_next       = 1'b0;
        pending_ops.push_back(p);
        case (mode)
            MODE_PUSH:
                if (plan_depth < CAP)
                    plan_depth++;
            MODE_POP:
                if (plan_depth > 0)
                    plan_depth--;
            MODE_DIGITS:
            begin
                digits = 0;
                n = longint'(value);
                do
                begin
                    digits++;
                    n = n / 10;
                end
                while (n > 0);
                plan_depth = (plan_depth + digits > CAP) ? CAP : plan_depth + digits;
            end
            default:
                ;
        endcase
    endtask

    // Random word: full range, small digits, medium numbers or extremes.
    function automatic logic signed [DATA_BITS-1:0] pick_word();
        case ($urandom_range(0, 7))
            0, 1, 2:
                return $urandom;
            3, 4:
                return $urandom_range(0, 9);
            5:
                return $urandom_range(0, 99999);
            default:
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
        endcase
    endfunction

    // Empty the stack, build a mirrored sequence, perhaps spoil it, then check.
    task automatic palindrome_run();
        logic signed [DATA_BITS-1:0] seq [$];
        int len;
        int sel;
        sel = $urandom_range(0, 9);
        repeat (plan_depth + $urandom_range(0, 1))
            queue_op(MODE_POP, pick_word());
        if (sel < 7)
            len = $urandom_range(0, 12);
        else if (sel < 9)
            len = $urandom_range(13, 32);
        else
            len = $urandom_range(33, 36);
        for (int i = 0; i < len; i++)
        begin
            if (i < (len + 1) / 2)
                seq.push_back(pick_word());
            else
                seq.push_back(seq[len - 1 - i]);
        end
        if (len > 0 && $urandom_range(0, 2) == 0)
            seq[$urandom_range(0, len - 1)] = pick_word();
        foreach (seq[k])
            queue_op(MODE_PUSH, seq[k]);
        queue_op(MODE_PAL, pick_word());
        if ($urandom_range(0, 1) == 0)
        begin
            queue_op(MODE_POP, pick_word());
            queue_op(MODE_PAL, pick_word());
        end
    endtask

    // Fill with digit pushes until full, push past the limit, then unwind a little.
    task automatic overflow_run();
        while (plan_depth < CAP)
            queue_op(MODE_DIGITS, ($urandom_range(0, 3) == 0) ? pick_word() :
                     $urandom_range(0, 32'h7FFF_FFFF));
        queue_op(MODE_PUSH, pick_word());
        queue_op(MODE_DIGITS, pick_word());
        queue_op(MODE_PAL, pick_word());
        repeat ($urandom_range(1, 8))
            queue_op(MODE_POP, pick_word());
    endtask

    // Field comparison of one result against its prediction
    task automatic compare_field(input string name, input logic signed [32:0] want,
                                 input logic signed [32:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Monitor: predict on each item transfer, check each result transfer.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        item_fired   = rst_n && item_ch.valid && item_ch.ready;
        result_fired = rst_n && result_ch.valid && result_ch.ready;
        if (item_fired)
            awaited_results.push_back(stack_apply(item_ch.data));
        if (result_fired)
        begin
            got = result_ch.data;
            if (awaited_results.size() == 0)
            begin
                $error("result transfer with no prediction waiting: depth_now %0d",
                       got.depth_now);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                compare_field("pop_value", 33'(want.pop_value), 33'(got.pop_value));
                compare_field("was_empty", 33'(want.was_empty), 33'(got.was_empty));
                compare_field("is_palindrome", 33'(want.is_palindrome),
                              33'(got.is_palindrome));
                compare_field("depth_now", 33'(want.depth_now), 33'(got.depth_now));
                compare_field("now_full", 33'(want.now_full), 33'(got.now_full));
            end
        end
    end

    // Item driver: presents queued items at the falling edge after a drawn gap.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_fired)
                send_gap = draw_wait(send_steady);
            if (!item_ch.valid || item_fired)
            begin
                if (send_gap > 0)
                begin
                    item_ch.valid <= 1'b0;
                    send_gap--;
                end
                else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].wait_idle && awaited_results.size() != 0))
                begin
                    item_ch.data  <= pending_ops[0].op;
                    item_ch.valid <= 1'b1;
                    void'(pending_ops.pop_front());
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls ready for a drawn number of cycles per transfer.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_fired)
                take_gap = draw_wait(take_steady);
            if (take_gap > 0)
            begin
                result_ch.ready <= 1'b0;
                take_gap--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Watchdog on the length of the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bounded_stack_with_palindrome_check verification failed");
            $finish;
        end
    end

    // Stimulus plan, reset and end of run
    initial
    begin
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;
        held_count      = 0;
        plan_depth      = 0;
        hold_next       = 1'b0;

        // Directed part: empty cases, extreme words, digit corner cases, overflow.
        queue_op(MODE_PAL, 32'sd0);
        queue_op(MODE_POP, 32'sd0);
        queue_op(MODE_PUSH, 32'sh7FFF_FFFF);
        queue_op(MODE_PUSH, 32'sh8000_0000);
        queue_op(MODE_PUSH, 32'sd0);
        queue_op(MODE_PUSH, -32'sd1);
        queue_op(MODE_PAL, 32'sh5555_AAAA);
        repeat (4)
            queue_op(MODE_POP, 32'shAAAA_5555);
        queue_op(MODE_DIGITS, 32'sd0);
        queue_op(MODE_DIGITS, 32'sh8000_0000);
        repeat (2)
            queue_op(MODE_POP, -32'sd1);
        queue_op(MODE_DIGITS, 32'sd12321);
        queue_op(MODE_PAL, 32'sd0);
        repeat (3)
            queue_op(MODE_DIGITS, 32'sh7FFF_FFFF);
        queue_op(MODE_PUSH, 32'sd5);
        queue_op(MODE_DIGITS, 32'sd7);
        queue_op(MODE_PAL, 32'sd0);
        queue_op(MODE_POP, 32'sd0);

        // Random part, shaped into sequences; the first one waits for idle.
        hold_next = 1'b1;
        while (pending_ops.size() < PLAN_ITEMS)
        begin
            if ($urandom_range(0, 39) == 0)
                hold_next = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    palindrome_run();
                4, 5:
                    overflow_run();
                6, 7:
                    repeat ($urandom_range(1, plan_depth + 2))
                        queue_op(MODE_POP, pick_word());
                default:
                    repeat ($urandom_range(1, 8))
                        queue_op(2'($urandom_range(0, 3)), pick_word());
            endcase
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || item_ch.valid)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("bounded_stack_with_palindrome_check verification clean");
        else
            $display("bounded_stack_with_palindrome_check verification failed");
        $finish;
    end

endmodule
